FILE: hw/rtl/btcs_pkg.sv
// Shared types and constants of the binomial-tree collective schedule block.
`default_nettype none
package btcs_pkg;

    // Largest group that the schedule supports.
    localparam int unsigned MAX_RANKS = 1024;

    // Request types.
    localparam logic [1:0] REQ_REDUCE  = 2'd0;
    localparam logic [1:0] REQ_BCAST   = 2'd1;
    localparam logic [1:0] REQ_ALLRED  = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // Step actions.
    localparam logic [2:0] ACT_SEND     = 3'd0;
    localparam logic [2:0] ACT_RECV_ADD = 3'd1;
    localparam logic [2:0] ACT_RECV_OVR = 3'd2;
    localparam logic [2:0] ACT_NONE     = 3'd3;
    localparam logic [2:0] ACT_BAD      = 3'd4;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_NODE_RANK  = 1'b0;
    localparam logic REG_GROUP_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [9:0]  partner_rank;
        logic [3:0]  round_index;
        logic        phase;
        logic [33:0] transfer_bytes;
    } t_step;

    typedef struct packed {
        logic capture;    // register the incoming request
        logic setup;      // register relative rank, clear round counter
        logic clr_round;  // restart the round counter for the broadcast phase
        logic step;       // evaluate one round and advance
        logic bcast;      // rounds follow the broadcast rule
        logic load_bad;   // schedule is a single bad-rank step
        logic load_none;  // schedule is a single empty step
        logic flush;      // move the held step out as the last one
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic none;
        logic is_reduce;
        logic is_bcast;
        logic loop_end;
        logic cand_stop;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/btcs_ctrl.sv
// Sequencing state machine of the binomial-tree collective schedule block.
`default_nettype none
module btcs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire btcs_pkg::t_dp_stat i_stat,
    output btcs_pkg::t_dp_cmd       o_cmd
);
    import btcs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RED   = 3'd2;
    localparam logic [2:0] S_BC    = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_stat.bad) begin
                    o_cmd.load_bad = 1'b1;
                    n_state        = S_FLUSH;
                end else if (i_stat.none) begin
                    o_cmd.load_none = 1'b1;
                    n_state         = S_FLUSH;
                end else if (i_stat.is_reduce) begin
                    n_state = S_RED;
                end else begin
                    n_state = S_BC;
                end
            end
            S_RED: begin
                if (i_stat.loop_end) begin
                    o_cmd.clr_round = i_stat.is_bcast;
                    n_state         = i_stat.is_bcast ? S_BC : S_FLUSH;
                end else if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    // A send to the parent ends the reduce phase.
                    if (i_stat.cand_stop) begin
                        o_cmd.clr_round = i_stat.is_bcast;
                        n_state         = i_stat.is_bcast ? S_BC : S_FLUSH;
                    end
                end
            end
            S_BC: begin
                o_cmd.bcast = 1'b1;
                if (i_stat.loop_end) begin
                    n_state = S_FLUSH;
                end else if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/btcs_datapath.sv
// Round evaluation, held step and output register of the collective schedule block.
`default_nettype none
module btcs_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire btcs_pkg::t_dp_cmd  i_cmd,
    output btcs_pkg::t_dp_stat      o_stat,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [9:0]         i_root_rank,
    input  wire logic [31:0]        i_element_count,
    input  wire logic [9:0]         i_node_rank,
    input  wire logic [10:0]        i_group_size,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_action,
    output logic [9:0]              o_partner_rank,
    output logic [3:0]              o_round_index,
    output logic                    o_phase,
    output logic [33:0]             o_transfer_bytes,
    output logic                    o_last_step
);
    import btcs_pkg::*;

    logic [1:0]  r_type;
    logic [9:0]  r_root;
    logic [33:0] r_bytes;
    logic [9:0]  r_rel;
    logic [3:0]  r_rd;
    t_step       r_pend;
    logic        r_pend_valid;
    t_step       r_out;
    logic        r_out_last;
    logic        r_out_valid;

    logic [10:0] rel_w;
    logic [10:0] root_w;
    logic [10:0] rel_next;
    logic [10:0] mask;
    logic [11:0] mask2;
    logic [10:0] x;
    logic [11:0] sum;
    logic [11:0] part;
    logic        cand_valid;
    logic        cand_stop;
    logic [2:0]  cand_act;
    t_step       cand;
    t_step       special;
    logic        out_free;
    logic        out_load;

    assign rel_w  = {1'b0, r_rel};
    assign root_w = {1'b0, r_root};
    assign mask   = 11'd1 << r_rd;
    assign mask2  = {mask, 1'b0};

    // Rank relative to the root, modulo the group size.
    always_comb begin
        if (i_node_rank >= r_root) begin
            rel_next = {1'b0, i_node_rank} - root_w;
        end else begin
            rel_next = {1'b0, i_node_rank} + i_group_size - root_w;
        end
    end

    // One round of the tree walk: which peer, if any, and what to do.
    always_comb begin
        cand_valid = 1'b0;
        cand_stop  = 1'b0;
        cand_act   = ACT_SEND;
        x          = '0;
        if (!i_cmd.bcast) begin
            if ((rel_w & mask) != 11'd0) begin
                cand_valid = 1'b1;
                cand_stop  = 1'b1;
                cand_act   = ACT_SEND;
                x          = rel_w & ~mask;
            end else if ((rel_w | mask) < i_group_size) begin
                cand_valid = 1'b1;
                cand_act   = ACT_RECV_ADD;
                x          = rel_w | mask;
            end
        end else begin
            if (rel_w < mask) begin
                if ((rel_w + mask) < i_group_size) begin
                    cand_valid = 1'b1;
                    cand_act   = ACT_SEND;
                    x          = rel_w + mask;
                end
            end else if ({1'b0, rel_w} < mask2) begin
                cand_valid = 1'b1;
                cand_act   = ACT_RECV_OVR;
                x          = rel_w - mask;
            end
        end
    end

    // Back to an actual rank: both terms are below the group size.
    assign sum  = {1'b0, x} + {1'b0, root_w};
    assign part = (sum >= {1'b0, i_group_size}) ? (sum - {1'b0, i_group_size}) : sum;

    always_comb begin
        cand.action         = cand_act;
        cand.partner_rank   = part[9:0];
        cand.round_index    = r_rd;
        cand.phase          = i_cmd.bcast;
        cand.transfer_bytes = r_bytes;
        special             = '0;
        special.action      = i_cmd.load_bad ? ACT_BAD : ACT_NONE;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (i_cmd.step && cand_valid && r_pend_valid) || i_cmd.flush;

    always_comb begin
        o_stat.bad       = (i_group_size == 11'd0) || (i_group_size > 11'(MAX_RANKS))
                           || ({1'b0, i_node_rank} >= i_group_size)
                           || (root_w >= i_group_size);
        o_stat.none      = (i_group_size == 11'd1) || (r_type == REQ_UNKNOWN);
        o_stat.is_reduce = (r_type == REQ_REDUCE) || (r_type == REQ_ALLRED);
        o_stat.is_bcast  = (r_type == REQ_BCAST) || (r_type == REQ_ALLRED);
        o_stat.loop_end  = (mask >= i_group_size);
        o_stat.cand_stop = cand_stop;
        o_stat.out_free  = out_free;
    end

    // Request and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_req_type;
            r_root  <= (i_req_type == REQ_ALLRED) ? 10'd0 : i_root_rank;
            r_bytes <= {i_element_count, 2'b00};
        end
        if (i_cmd.setup) begin
            r_rel <= rel_next[9:0];
        end
        if (i_cmd.setup || i_cmd.clr_round) begin
            r_rd <= 4'd0;
        end else if (i_cmd.step) begin
            r_rd <= r_rd + 4'd1;
        end
    end

    // A step is held until the next one shows whether it was the last.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bad || i_cmd.load_none) begin
            r_pend <= special;
        end else if (i_cmd.step && cand_valid) begin
            r_pend <= cand;
        end
        if (out_load) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_bad || i_cmd.load_none || (i_cmd.step && cand_valid)) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out.action;
    assign o_partner_rank   = r_out.partner_rank;
    assign o_round_index    = r_out.round_index;
    assign o_phase          = r_out.phase;
    assign o_transfer_bytes = r_out.transfer_bytes;
    assign o_last_step      = r_out_last;

endmodule
`default_nettype wire

FILE: hw/rtl/binomial_tree_collective_schedule_core.sv
// Binomial-tree collective schedule: one request in, this node's steps out, one per transfer.
//
// A request (type, root rank, element count) is a transfer on the input channel when
// i_in_valid is high and o_in_stall is low. The block then lists this node's steps of a
// binomial-tree reduce, broadcast or allreduce on the output channel, one step per
// transfer, with o_last_step marking the final one. node_rank (address 0) and
// group_size (address 4) are set over the APB port; the user must set them only while
// no request is in flight, as the block does not enforce it. Steps: the request is taken,
// then ranks are checked and the relative rank is formed, then the tree rounds of each
// phase are evaluated until the phase ends, and last the held last step is released.
// A step is held until the next one is found, and only then is it loaded into the output
// register. The round walk is the limit: one round is evaluated per cycle while the
// output register is free to take a step.
// One request is handled at a time; o_in_stall is high from acceptance until the last
// step has been loaded into the output register, which may still be waiting.
// When i_out_stall is high the output step holds, and the round walk pauses while a step waits in it.
// Reset (synchronous, active low) empties the block and sets node_rank 0, group_size 1.
`default_nettype none
module binomial_tree_collective_schedule_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [9:0]  i_root_rank,
    input  wire logic [31:0] i_element_count,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_action,
    output logic [9:0]       o_partner_rank,
    output logic [3:0]       o_round_index,
    output logic             o_phase,
    output logic [33:0]      o_transfer_bytes,
    output logic             o_last_step
);
    import btcs_pkg::*;

    logic [9:0]  r_node_rank;
    logic [10:0] r_group_size;
    logic        cfg_wr;
    t_dp_cmd     cmd;
    t_dp_stat    stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_rank  <= 10'd0;
            r_group_size <= 11'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NODE_RANK) begin
                r_node_rank <= pwdata[9:0];
            end else begin
                r_group_size <= pwdata[10:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_NODE_RANK) begin
            prdata = {22'd0, r_node_rank};
        end else begin
            prdata = {21'd0, r_group_size};
        end
    end

    btcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    btcs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req_type),
        .i_root_rank      (i_root_rank),
        .i_element_count  (i_element_count),
        .i_node_rank      (r_node_rank),
        .i_group_size     (r_group_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_partner_rank   (o_partner_rank),
        .o_round_index    (o_round_index),
        .o_phase          (o_phase),
        .o_transfer_bytes (o_transfer_bytes),
        .o_last_step      (o_last_step)
    );

    // A request transfer always closes the input until its schedule is formed.
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request transfer");

    // Bad-rank and empty schedules are a single step.
    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_BAD || o_action == ACT_NONE)) |-> o_last_step)
        else $error("single-step schedule not marked last");

    // Every real peer lies inside the group, and every round index is at most 9.
    a_partner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_SEND || o_action == ACT_RECV_ADD
                         || o_action == ACT_RECV_OVR))
        |-> ({1'b0, o_partner_rank} < r_group_size && o_round_index <= 4'd9))
        else $error("step partner or round out of range");

endmodule
`default_nettype wire

FILE: tb/sv/binomial_tree_collective_schedule_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the binomial-tree collective schedule core.
module binomial_tree_collective_schedule_core_test;
    import btcs_pkg::*;

    localparam int unsigned TIMEOUT_NS   = 20_000_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_COUNT  = 9;
    localparam int unsigned PHASE_ITEMS  = 17;

    typedef struct packed {
        t_step step;
        logic  last;
    } sched_step_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [9:0]  i_root_rank = '0;
    logic [31:0] i_element_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_action;
    logic [9:0]  o_partner_rank;
    logic [3:0]  o_round_index;
    logic        o_phase;
    logic [33:0] o_transfer_bytes;
    logic        o_last_step;

    // Local copy of the two configuration registers, as after reset.
    logic [9:0]  sched_node_rank = 10'd0;
    logic [10:0] sched_group_size = 11'd1;

    sched_step_t pending_steps[$];
    int          error_count = 0;
    bit          sender_idles = 1'b1;
    int          stall_mode = 1;
    int          burst_left = 0;
    int          hold_trigger = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    binomial_tree_collective_schedule_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_root_rank      (i_root_rank),
        .i_element_count  (i_element_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_partner_rank   (o_partner_rank),
        .o_round_index    (o_round_index),
        .o_phase          (o_phase),
        .o_transfer_bytes (o_transfer_bytes),
        .o_last_step      (o_last_step)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void push_step(logic [2:0] act, int unsigned partner, int unsigned rnd,
                                      logic ph, logic [33:0] bytes);
        sched_step_t s;
        s.step.action         = act;
        s.step.partner_rank   = partner[9:0];
        s.step.round_index    = rnd[3:0];
        s.step.phase          = ph;
        s.step.transfer_bytes = bytes;
        s.last                = 1'b0;
        pending_steps.push_back(s);
    endfunction

    // Appends this node's schedule for one request to the pending steps.
    function automatic void predict_schedule(logic [1:0] req, logic [9:0] root_in,
                                             logic [31:0] count);
        int unsigned p, rank, root, rel, mask, rnd;
        logic [33:0] bytes;
        p     = 32'(sched_group_size);
        rank  = 32'(sched_node_rank);
        root  = (req == REQ_ALLRED) ? 32'd0 : 32'(root_in);
        bytes = {count, 2'b00};
        if (p == 0 || p > MAX_RANKS || rank >= p || root >= p) begin
            push_step(ACT_BAD, 0, 0, 1'b0, '0);
        end else if (p == 1 || req == REQ_UNKNOWN) begin
            push_step(ACT_NONE, 0, 0, 1'b0, '0);
        end else begin
            rel = (rank + p - root) % p;
            if (req == REQ_REDUCE || req == REQ_ALLRED) begin
                mask = 1;
                rnd  = 0;
                // Gather from children while our bit is clear, then hand off to the parent.
                while (mask < p) begin
                    if ((rel & mask) != 0) begin
                        push_step(ACT_SEND, ((rel & ~mask) + root) % p, rnd, 1'b0, bytes);
                        break;
                    end
                    if ((rel | mask) < p)
                        push_step(ACT_RECV_ADD, ((rel | mask) + root) % p, rnd, 1'b0, bytes);
                    mask <<= 1;
                    rnd++;
                end
            end
            if (req == REQ_BCAST || req == REQ_ALLRED) begin
                mask = 1;
                rnd  = 0;
                while (mask < p) begin
                    if (rel < mask) begin
                        if (rel + mask < p)
                            push_step(ACT_SEND, (rel + mask + root) % p, rnd, 1'b1, bytes);
                    end else if (rel < 2 * mask) begin
                        push_step(ACT_RECV_OVR, (rel - mask + root) % p, rnd, 1'b1, bytes);
                    end
                    mask <<= 1;
                    rnd++;
                end
            end
        end
        pending_steps[pending_steps.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [33:0] want_v, logic [33:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    // Step checker and receiver stall pattern.
    always @(posedge i_clk) begin : step_receiver
        sched_step_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_steps.size() == 0) begin
                $display("%0t: step transfer with none expected: expected nothing, got action %0d",
                         $time, o_action);
                error_count++;
            end else begin
                want = pending_steps.pop_front();
                check_field("action", 34'(want.step.action), 34'(o_action));
                check_field("partner_rank", 34'(want.step.partner_rank), 34'(o_partner_rank));
                check_field("round_index", 34'(want.step.round_index), 34'(o_round_index));
                check_field("phase", 34'(want.step.phase), 34'(o_phase));
                check_field("transfer_bytes", want.step.transfer_bytes, o_transfer_bytes);
                check_field("last_step", 34'(want.last), 34'(o_last_step));
            end
        end
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_mode == 0) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Writes one register, then reads it back.
    task automatic write_register(logic reg_index, logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_index == REG_NODE_RANK)
            sched_node_rank = value[9:0];
        else
            sched_group_size = value[10:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_index == REG_NODE_RANK)
            check_field("node_rank readback", 34'(sched_node_rank), 34'(readback[9:0]));
        else
            check_field("group_size readback", 34'(sched_group_size), 34'(readback[10:0]));
    endtask

    // Offers one request until it transfers; valid stays high through a burst.
    task automatic send_request(logic [1:0] req, logic [9:0] root, logic [31:0] count);
        int gap;
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_root_rank     <= root;
        i_element_count <= count;
        do @(posedge i_clk); while (o_in_stall);
        predict_schedule(req, root, count);
        if (sender_idles) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(0, 7);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A single rank, and an unknown request type, give one empty step.
    task automatic test_single_rank();
        send_request(REQ_REDUCE, 10'd0, 32'd0);
        send_request(REQ_BCAST, 10'd0, 32'hFFFF_FFFF);
        send_request(REQ_ALLRED, 10'd1023, 32'd7);
        send_request(REQ_UNKNOWN, 10'd0, 32'd1);
        wait_idle();
    endtask

    task automatic test_bad_rank();
        write_register(REG_GROUP_SIZE, 32'd8);
        write_register(REG_NODE_RANK, 32'd3);
        send_request(REQ_REDUCE, 10'd8, 32'd5);
        send_request(REQ_BCAST, 10'd1023, 32'd5);
        // Allreduce ignores the root, so this one is a valid tree.
        send_request(REQ_ALLRED, 10'd1023, 32'd5);
        send_request(REQ_UNKNOWN, 10'd9, 32'd5);
        wait_idle();
        write_register(REG_NODE_RANK, 32'd8);
        send_request(REQ_REDUCE, 10'd0, 32'd5);
        wait_idle();
        write_register(REG_GROUP_SIZE, 32'd0);
        write_register(REG_NODE_RANK, 32'd0);
        send_request(REQ_BCAST, 10'd0, 32'd5);
        wait_idle();
        write_register(REG_GROUP_SIZE, 32'd2047);
        send_request(REQ_REDUCE, 10'd0, 32'd5);
        wait_idle();
        write_register(REG_GROUP_SIZE, 32'd1025);
        write_register(REG_NODE_RANK, 32'd1023);
        send_request(REQ_ALLRED, 10'd0, 32'd5);
        wait_idle();
    endtask

    task automatic test_tree_walks();
        write_register(REG_GROUP_SIZE, 32'd1024);
        write_register(REG_NODE_RANK, 32'd0);
        send_request(REQ_ALLRED, 10'd0, 32'hFFFF_FFFF);
        send_request(REQ_REDUCE, 10'd0, 32'd0);
        send_request(REQ_BCAST, 10'd1023, 32'd1);
        wait_idle();
        write_register(REG_NODE_RANK, 32'd1023);
        send_request(REQ_ALLRED, 10'd0, 32'h1234_5678);
        send_request(REQ_REDUCE, 10'd1023, 32'hFFFF_FFFF);
        send_request(REQ_BCAST, 10'd512, 32'd3);
        wait_idle();
        write_register(REG_GROUP_SIZE, 32'd7);
        write_register(REG_NODE_RANK, 32'd5);
        send_request(REQ_REDUCE, 10'd6, 32'd100);
        send_request(REQ_BCAST, 10'd6, 32'd100);
        send_request(REQ_UNKNOWN, 10'd2, 32'd100);
        send_request(REQ_ALLRED, 10'd4, 32'd100);
        wait_idle();
    endtask

    // The receiver holds off while full allreduces keep coming, so the input stalls.
    task automatic test_output_backpressure();
        write_register(REG_GROUP_SIZE, 32'd1024);
        write_register(REG_NODE_RANK, 32'd0);
        sender_idles = 1'b0;
        hold_trigger <= hold_trigger + 1;
        repeat (6)
            send_request(REQ_ALLRED, 10'($urandom_range(0, 1023)), $urandom());
        wait_idle();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_phases();
        int unsigned world, rank, pick;
        logic [1:0]  req;
        logic [9:0]  root;
        logic [31:0] count;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       world = 0;
                1:       world = $urandom_range(MAX_RANKS + 1, 2047);
                2:       world = 1;
                3:       world = MAX_RANKS;
                4, 5, 6, 7, 8, 9: world = $urandom_range(2, 16);
                default: world = $urandom_range(2, MAX_RANKS);
            endcase
            if (world >= 1 && world <= MAX_RANKS && $urandom_range(0, 7) != 0)
                rank = $urandom_range(0, world - 1);
            else
                rank = $urandom_range(0, 1023);
            write_register(REG_GROUP_SIZE, 32'(world));
            write_register(REG_NODE_RANK, 32'(rank));
            // One phase runs with neither side idling.
            if (ph == 4) begin
                sender_idles = 1'b0;
                stall_mode   = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    req = REQ_UNKNOWN;
                else if (pick <= 3)
                    req = REQ_REDUCE;
                else if (pick <= 6)
                    req = REQ_BCAST;
                else
                    req = REQ_ALLRED;
                if (world >= 1 && world <= MAX_RANKS && $urandom_range(0, 3) != 0)
                    root = 10'($urandom_range(0, world - 1));
                else
                    root = 10'($urandom_range(0, 1023));
                case ($urandom_range(0, 7))
                    0:       count = 32'd0;
                    1:       count = 32'hFFFF_FFFF;
                    default: count = $urandom();
                endcase
                send_request(req, root, count);
            end
            wait_idle();
            sender_idles = 1'b1;
            stall_mode   = 1;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_rank();
        test_bad_rank();
        test_tree_walks();
        test_output_backpressure();
        test_random_phases();
        wait_idle();
        repeat (30) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
